// ===== src/snms_pkg.sv =====
`default_nettype none
package snms_pkg;

  localparam int CFG_W = 11;

  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] RESET_WIDTH  = 11'd512;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 11'd512;

  // tan(22.5) and tan(67.5) in 8-bit fraction
  localparam logic [19:0] TAN_LO = 20'd106;
  localparam logic [19:0] TAN_HI = 20'd618;

  typedef enum logic [1:0] {
    DIR_HORZ = 2'd0,
    DIR_ANTI = 2'd1,
    DIR_VERT = 2'd2,
    DIR_DIAG = 2'd3
  } dir_t;

  typedef enum logic [1:0] {
    OFS_PREV = 2'd0,
    OFS_SAME = 2'd1,
    OFS_NEXT = 2'd2
  } ofs_t;

endpackage
`default_nettype wire

// ===== src/snms_if.sv =====
`default_nettype none
interface snms_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] pixel;
  modport source (output valid, output cmd, output pixel, input ready);
  modport sink (input valid, input cmd, input pixel, output ready);
endinterface

interface snms_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] edge_res;
  logic       last;
  modport source (output valid, output edge_res, output last, input ready);
  modport sink (input valid, input edge_res, input last, output ready);
endinterface
`default_nettype wire

// ===== src/snms_ram.sv =====
`default_nettype none
module snms_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/snms_sqrt.sv =====
`default_nettype none
module snms_sqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [15:0] value,
  output logic             done,
  output logic [7:0]       root
);

  logic [15:0] rem_r, rem_nxt;
  logic [15:0] res_r, res_nxt;
  logic [15:0] bit_r, bit_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [16:0] trial;

  always_comb begin
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {1'b0, res_r} + {1'b0, bit_r};
    if (start) begin
      rem_nxt  = value;
      res_nxt  = 16'd0;
      bit_nxt  = 16'h4000;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if ({1'b0, rem_r} >= trial) begin
        rem_nxt = rem_r - trial[15:0];
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r == 16'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign done = done_r;
  assign root = res_r[7:0];

endmodule
`default_nettype wire

// ===== src/sobel_nonmax_suppression.sv =====
// Channel  Dir  Payload                 Request taken when
// in_ch    in   cmd, pixel              valid && ready
// out_ch   out  edge_res, last          valid && ready
// cfg_*    in   cfg_index, cfg_data     cfg_we
//
// Each request runs window reads through the single read port of each line
// memory, then gradient math, the bit-serial square root and writeback.
// After reset or a register write, in_ch.ready stays low until pend_r is zero.
// A result still waiting in out_ch holds the next result in the output state,
// and the next request waits with it.
// Line memories are not cleared; every entry is written before it is read.
`default_nettype none
module sobel_nonmax_suppression #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_index,
  input  wire logic [snms_pkg::CFG_W-1:0] cfg_data,
  snms_in_if.sink                         in_ch,
  snms_out_if.source                      out_ch
);

  localparam int W_BITS = $clog2(MAX_WIDTH + 1);
  localparam int H_BITS = snms_pkg::CFG_W;
  localparam int FB     = W_BITS + H_BITS;
  localparam int TB     = FB + 1;
  localparam int A      = $clog2(2 * MAX_WIDTH + 4);
  localparam int DEPTH  = 2 ** A;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_READ = 7'b0000010,
    ST_SUM  = 7'b0000100,
    ST_SQ   = 7'b0001000,
    ST_ROOT = 7'b0010000,
    ST_WB   = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

  state_t st_r, st_nxt;

  logic [H_BITS-1:0] cfg_w_r, cfg_h_r;
  logic [1:0]        pend_r;
  logic [W_BITS-1:0] w_eff, w_r;
  logic [H_BITS-1:0] h_eff, h_r;
  logic [FB-1:0]     frame_r;
  logic [TB-1:0]     w1_r, w22_r, total_r;

  logic [TB-1:0]     t_r;
  logic [H_BITS-1:0] rq_r, rp_r;
  logic [W_BITS-1:0] cq_r, cp_r;
  logic              q_act_r, p_act_r;
  logic [3:0]        k_r;

  logic              rd_en_r, rd_pin_r, rd_min_r;
  logic [3:0]        rd_k_r;
  logic              min8_r;
  logic [7:0]        pw_r [9];
  logic [7:0]        mw_r [9];
  logic [1:0]        dir_p_r;

  logic [9:0]        ax_r, ay_r;
  logic              sgn_r;
  logic              sat_r;
  logic [1:0]        dir_q_r;

  logic              out_valid_r, out_last_r;
  logic [7:0]        out_edge_r;
  logic              res_last_r;
  logic [7:0]        res_edge_r;

  logic              in_fire;
  logic              pix_we;
  logic [7:0]        pix_wdata, pix_rdata;
  logic [A-1:0]      pix_raddr, mag_raddr, mag_waddr;
  logic              mag_we;
  logic [9:0]        mag_wdata, mag_rdata;
  snms_pkg::ofs_t    row_sel, col_sel;
  logic [A-1:0]      roff, cadj;
  logic              pin, min;

  logic [9:0]        sx_p, sx_n, sy_p, sy_n;
  logic signed [11:0] gx, gy;
  logic [20:0]       sq_sum;
  logic [19:0]       ay256;
  logic              sq_done;
  logic [7:0]        sq_root, mag;
  logic [7:0]        m8, nb_a, nb_b;
  logic              load_out;
  logic [TB-1:0]     t_inc;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (st_r == ST_IDLE) && (pend_r == 2'd0);

  always_comb begin
    if (cfg_w_r < H_BITS'(3)) begin
      w_eff = W_BITS'(3);
    end else if (32'(cfg_w_r) > MAX_WIDTH) begin
      w_eff = W_BITS'(MAX_WIDTH);
    end else begin
      w_eff = W_BITS'(cfg_w_r);
    end
    h_eff = (cfg_h_r < H_BITS'(3)) ? H_BITS'(3) : cfg_h_r;
  end

  always_comb begin
    case (k_r) inside
      4'd0, 4'd1, 4'd2: row_sel = snms_pkg::OFS_PREV;
      4'd3, 4'd4, 4'd5: row_sel = snms_pkg::OFS_SAME;
      default:          row_sel = snms_pkg::OFS_NEXT;
    endcase
    case (k_r) inside
      4'd0, 4'd3, 4'd6: col_sel = snms_pkg::OFS_PREV;
      4'd1, 4'd4, 4'd7: col_sel = snms_pkg::OFS_SAME;
      default:          col_sel = snms_pkg::OFS_NEXT;
    endcase
    unique case (row_sel)
      snms_pkg::OFS_PREV: roff = A'({w_r, 1'b0});
      snms_pkg::OFS_SAME: roff = A'(w_r);
      default:            roff = '0;
    endcase
    unique case (col_sel)
      snms_pkg::OFS_PREV: cadj = A'(2);
      snms_pkg::OFS_SAME: cadj = A'(1);
      default:            cadj = '0;
    endcase
    pin = 1'b1;
    min = 1'b1;
    unique case (row_sel)
      snms_pkg::OFS_PREV: begin
        pin = pin && (rq_r != '0);
        min = min && (rp_r != '0);
      end
      snms_pkg::OFS_NEXT: begin
        pin = pin && (rq_r + H_BITS'(1) < h_r);
        min = min && (rp_r + H_BITS'(1) < h_r);
      end
      default: ;
    endcase
    unique case (col_sel)
      snms_pkg::OFS_PREV: begin
        pin = pin && (cq_r != '0);
        min = min && (cp_r != '0);
      end
      snms_pkg::OFS_NEXT: begin
        pin = pin && (cq_r + W_BITS'(1) < w_r);
        min = min && (cp_r + W_BITS'(1) < w_r);
      end
      default: ;
    endcase
  end

  assign pix_raddr = t_r[A-1:0] - roff - cadj;
  assign mag_raddr = pix_raddr - A'(w_r) - A'(1);
  assign mag_waddr = t_r[A-1:0] - A'(w_r) - A'(1);

  assign pix_we    = in_fire && (t_r < TB'(frame_r));
  assign pix_wdata = in_ch.cmd ? 8'd0 : in_ch.pixel;

  snms_ram #(.DEPTH(DEPTH), .WIDTH(8)) u_pix_ram (
    .clk     (clk),
    .we      (pix_we),
    .waddr   (t_r[A-1:0]),
    .wdata   (pix_wdata),
    .raddr   (pix_raddr),
    .rdata_r (pix_rdata)
  );

  assign mag_we    = (st_r == ST_WB) && q_act_r;
  assign mag_wdata = {dir_q_r, mag};

  snms_ram #(.DEPTH(DEPTH), .WIDTH(10)) u_mag_ram (
    .clk     (clk),
    .we      (mag_we),
    .waddr   (mag_waddr),
    .wdata   (mag_wdata),
    .raddr   (mag_raddr),
    .rdata_r (mag_rdata)
  );

  always_comb begin
    sx_p = 10'(pw_r[2]) + 10'({pw_r[5], 1'b0}) + 10'(pw_r[8]);
    sx_n = 10'(pw_r[0]) + 10'({pw_r[3], 1'b0}) + 10'(pw_r[6]);
    sy_p = 10'(pw_r[6]) + 10'({pw_r[7], 1'b0}) + 10'(pw_r[8]);
    sy_n = 10'(pw_r[0]) + 10'({pw_r[1], 1'b0}) + 10'(pw_r[2]);
    gx   = $signed({2'b00, sx_p}) - $signed({2'b00, sx_n});
    gy   = $signed({2'b00, sy_p}) - $signed({2'b00, sy_n});
  end

  assign sq_sum = 21'(ax_r * ax_r) + 21'(ay_r * ay_r);
  assign ay256  = {2'b00, ay_r, 8'd0};

  snms_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (st_r == ST_SQ),
    .value (sq_sum[15:0]),
    .done  (sq_done),
    .root  (sq_root)
  );

  assign mag = sat_r ? 8'hFF : sq_root;
  assign m8  = min8_r ? mag : 8'd0;

  always_comb begin
    case (snms_pkg::dir_t'(dir_p_r))
      snms_pkg::DIR_HORZ: begin nb_a = mw_r[3]; nb_b = mw_r[5]; end
      snms_pkg::DIR_ANTI: begin nb_a = mw_r[2]; nb_b = mw_r[6]; end
      snms_pkg::DIR_VERT: begin nb_a = mw_r[1]; nb_b = mw_r[7]; end
      default:            begin nb_a = mw_r[0]; nb_b = m8;      end
    endcase
  end

  assign load_out = (st_r == ST_OUT) && p_act_r && (!out_valid_r || out_ch.ready);
  assign t_inc    = t_r + TB'(1);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (in_fire) st_nxt = ST_READ;
      ST_READ: if (k_r == 4'd9) st_nxt = ST_SUM;
      ST_SUM:  st_nxt = ST_SQ;
      ST_SQ:   st_nxt = ST_ROOT;
      ST_ROOT: if (sq_done) st_nxt = ST_WB;
      ST_WB:   st_nxt = ST_OUT;
      ST_OUT:  if (!p_act_r || load_out) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cfg_w_r     <= snms_pkg::RESET_WIDTH;
      cfg_h_r     <= snms_pkg::RESET_HEIGHT;
      pend_r      <= 2'd3;
      t_r         <= '0;
      rq_r        <= '0;
      cq_r        <= '0;
      rp_r        <= '0;
      cp_r        <= '0;
      k_r         <= '0;
      rd_en_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      rd_en_r <= (st_r == ST_READ) && (k_r != 4'd9);
      if (cfg_we) begin
        unique case (cfg_index)
          snms_pkg::CFG_IMAGE_WIDTH:  cfg_w_r <= cfg_data;
          snms_pkg::CFG_IMAGE_HEIGHT: cfg_h_r <= cfg_data;
          default: ;
        endcase
        pend_r <= 2'd3;
        t_r    <= '0;
        rq_r   <= '0;
        cq_r   <= '0;
        rp_r   <= '0;
        cp_r   <= '0;
      end else begin
        if (pend_r != 2'd0) pend_r <= pend_r - 2'd1;
        if (st_r == ST_WB) begin
          if (t_inc == total_r) begin
            t_r  <= '0;
            rq_r <= '0;
            cq_r <= '0;
            rp_r <= '0;
            cp_r <= '0;
          end else begin
            t_r <= t_inc;
            if (q_act_r) begin
              if (cq_r + W_BITS'(1) == w_r) begin
                cq_r <= '0;
                rq_r <= rq_r + H_BITS'(1);
              end else begin
                cq_r <= cq_r + W_BITS'(1);
              end
            end
            if (p_act_r) begin
              if (cp_r + W_BITS'(1) == w_r) begin
                cp_r <= '0;
                rp_r <= rp_r + H_BITS'(1);
              end else begin
                cp_r <= cp_r + W_BITS'(1);
              end
            end
          end
        end
      end
      if (in_fire) begin
        k_r <= '0;
      end else if (st_r == ST_READ) begin
        k_r <= k_r + 4'd1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    w_r     <= w_eff;
    h_r     <= h_eff;
    frame_r <= FB'(w_r) * FB'(h_r);
    w1_r    <= TB'(w_r) + TB'(1);
    w22_r   <= TB'({w_r, 1'b0}) + TB'(2);
    total_r <= TB'(frame_r) + w22_r;

    if (in_fire) begin
      q_act_r <= (t_r >= w1_r) && (t_r < TB'(frame_r) + w1_r);
      p_act_r <= (t_r >= w22_r);
    end

    rd_k_r   <= k_r;
    rd_pin_r <= pin;
    rd_min_r <= min;
    if (rd_en_r) begin
      pw_r[rd_k_r] <= rd_pin_r ? pix_rdata : 8'd0;
      mw_r[rd_k_r] <= rd_min_r ? mag_rdata[7:0] : 8'd0;
      if (rd_k_r == 4'd4) dir_p_r <= mag_rdata[9:8];
      if (rd_k_r == 4'd8) min8_r <= rd_min_r;
    end

    if (st_r == ST_SUM) begin
      ax_r  <= gx[11] ? 10'(-gx) : 10'(gx);
      ay_r  <= gy[11] ? 10'(-gy) : 10'(gy);
      sgn_r <= gx[11] ^ gy[11];
    end

    if (st_r == ST_SQ) begin
      sat_r <= (sq_sum >= 21'd65536);
      if (ay256 < 20'(ax_r) * snms_pkg::TAN_LO) begin
        dir_q_r <= snms_pkg::DIR_HORZ;
      end else if (ay256 < 20'(ax_r) * snms_pkg::TAN_HI) begin
        dir_q_r <= sgn_r ? snms_pkg::DIR_ANTI : snms_pkg::DIR_DIAG;
      end else begin
        dir_q_r <= snms_pkg::DIR_VERT;
      end
    end

    if (st_r == ST_WB) begin
      res_edge_r <= (mw_r[4] >= nb_a && mw_r[4] >= nb_b) ? mw_r[4] : 8'd0;
      res_last_r <= (t_inc == total_r);
    end

    if (load_out) begin
      out_edge_r <= res_edge_r;
      out_last_r <= res_last_r;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.edge_res = out_edge_r;
  assign out_ch.last     = out_last_r;

  a_fire_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (st_r == ST_READ) && (k_r == 4'd0))
    else $error("read sequence did not start after request");

  a_q_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_WB) && q_act_r |-> (rq_r < h_r) && (cq_r < w_r))
    else $error("gradient position outside frame");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_WB) && (t_inc == total_r) |->
      p_act_r && (rp_r + H_BITS'(1) == h_r) && (cp_r + W_BITS'(1) == w_r))
    else $error("final result not at final pixel");

  a_root_timing: assert property (@(posedge clk) disable iff (!rst_n)
    sq_done |-> (st_r == ST_ROOT))
    else $error("square root finished outside root state");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready && (st_r == ST_OUT) && p_act_r |=> (st_r == ST_OUT))
    else $error("result slot overwritten");

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none
module tb;
  import snms_pkg::*;

  localparam int MAXW     = 1024;
  localparam int HIST     = 2 * MAXW + 4;
  localparam int DIRL     = MAXW + 2;
  localparam int WD_LIMIT = 3000;

  typedef logic [7:0] win_t [9];

  typedef struct packed {
    logic       cmd;
    logic [7:0] pixel;
  } pix_req_t;

  typedef struct packed {
    logic [7:0] edge_res;
    logic       last;
  } edge_res_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic                cfg_index = 1'b0;
  logic [CFG_W-1:0]    cfg_data = '0;

  snms_in_if  in_if ();
  snms_out_if out_if ();

  sobel_nonmax_suppression i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_if),
    .out_ch    (out_if)
  );

  always #5 clk = ~clk;

  pix_req_t  pixel_fifo [$];
  edge_res_t edge_fifo [$];
  int        errors = 0;
  int        phase = 0;
  bit        in_took = 1'b0;

  // thinning model state
  int unsigned img_w = RESET_WIDTH;
  int unsigned img_h = RESET_HEIGHT;
  int unsigned pos = 0;
  logic [7:0]  pix_hist [HIST];
  logic [7:0]  mag_hist [HIST];
  dir_t        dir_hist [DIRL];

  initial begin
    in_if.valid = 1'b0;
    in_if.cmd = 1'b0;
    in_if.pixel = '0;
    out_if.ready = 1'b0;
    foreach (pix_hist[i]) pix_hist[i] = '0;
    foreach (mag_hist[i]) mag_hist[i] = '0;
    foreach (dir_hist[i]) dir_hist[i] = DIR_HORZ;
  end

  function automatic int unsigned clamp_w(int unsigned v);
    return (v < 3) ? 3 : (v > MAXW) ? MAXW : v;
  endfunction

  function automatic int unsigned clamp_h(int unsigned v);
    return (v < 3) ? 3 : v;
  endfunction

  function automatic win_t neighborhood(bit from_mag, int unsigned p, int unsigned w,
                                        int unsigned h);
    win_t win;
    int r, c, rr, cc;
    r = p / w;
    c = p % w;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        rr = r + dr;
        cc = c + dc;
        win[(dr + 1) * 3 + dc + 1] = 8'd0;
        if (rr >= 0 && rr < int'(h) && cc >= 0 && cc < int'(w))
          win[(dr + 1) * 3 + dc + 1] = from_mag ? mag_hist[(rr * w + cc) % HIST]
                                                : pix_hist[(rr * w + cc) % HIST];
      end
    end
    return win;
  endfunction

  function automatic int unsigned root_floor(int unsigned s);
    int unsigned r = 0;
    while ((r + 1) * (r + 1) <= s) r++;
    return r;
  endfunction

  function automatic void gradient_at(int unsigned q, int unsigned w, int unsigned h);
    win_t p;
    int gx, gy;
    int unsigned ax, ay, s, mag;
    dir_t d;
    p = neighborhood(1'b0, q, w, h);
    gx = (int'(p[2]) + 2 * int'(p[5]) + int'(p[8])) - (int'(p[0]) + 2 * int'(p[3]) + int'(p[6]));
    gy = (int'(p[6]) + 2 * int'(p[7]) + int'(p[8])) - (int'(p[0]) + 2 * int'(p[1]) + int'(p[2]));
    ax = (gx < 0) ? -gx : gx;
    ay = (gy < 0) ? -gy : gy;
    s = ax * ax + ay * ay;
    mag = (s >= 65536) ? 255 : root_floor(s);
    if (mag > 255) mag = 255;
    if (256 * ay < 106 * ax) d = DIR_HORZ;
    else if (256 * ay < 618 * ax) d = ((gx < 0) != (gy < 0)) ? DIR_ANTI : DIR_DIAG;
    else d = DIR_VERT;
    mag_hist[q % HIST] = mag[7:0];
    dir_hist[q % DIRL] = d;
  endfunction

  function automatic logic [7:0] thin_at(int unsigned p, int unsigned w, int unsigned h);
    win_t m;
    logic [7:0] a, b;
    m = neighborhood(1'b1, p, w, h);
    case (dir_hist[p % DIRL])
      DIR_HORZ: begin a = m[3]; b = m[5]; end
      DIR_ANTI: begin a = m[2]; b = m[6]; end
      DIR_VERT: begin a = m[1]; b = m[7]; end
      default:  begin a = m[0]; b = m[8]; end
    endcase
    return (m[4] >= a && m[4] >= b) ? m[4] : 8'd0;
  endfunction

  function automatic void predict_edge(pix_req_t req);
    int unsigned w, h, frame, total, t, p;
    edge_res_t res;
    w = clamp_w(img_w);
    h = clamp_h(img_h);
    frame = w * h;
    total = frame + 2 * w + 2;
    t = (pos >= total) ? 0 : pos;
    if (t < frame) pix_hist[t % HIST] = req.cmd ? 8'd0 : req.pixel;
    if (t >= w + 1 && t - (w + 1) < frame) gradient_at(t - (w + 1), w, h);
    if (t >= 2 * w + 2 && t - (2 * w + 2) < frame) begin
      p = t - (2 * w + 2);
      res.edge_res = thin_at(p, w, h);
      res.last = (p == frame - 1);
      edge_fifo.push_back(res);
    end
    t++;
    pos = (t >= total) ? 0 : t;
  endfunction

  task automatic report(string what, int got, int want);
    errors++;
    $display("error at %0t: %s got %0d want %0d", $realtime, what, got, want);
  endtask

  // monitor and model update
  always @(posedge clk) begin
    edge_res_t want;
    in_took = rst_n && in_if.valid && in_if.ready;
    if (!rst_n) begin
      img_w = RESET_WIDTH;
      img_h = RESET_HEIGHT;
      pos = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (edge_fifo.size() == 0) begin
          report("unexpected result, edge_res", out_if.edge_res, 0);
        end else begin
          want = edge_fifo.pop_front();
          if (out_if.edge_res !== want.edge_res) report("edge_res", out_if.edge_res, want.edge_res);
          if (out_if.last !== want.last) report("last", out_if.last, want.last);
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_IMAGE_WIDTH) img_w = cfg_data;
        else img_h = cfg_data;
        pos = 0;
      end
      if (in_took) predict_edge('{cmd: in_if.cmd, pixel: in_if.pixel});
    end
  end

  function automatic bit idle_now(bit sender);
    int pct;
    case (phase)
      0: pct = sender ? 27 : 84;
      1: pct = sender ? 84 : 27;
      default: pct = 0;
    endcase
    return $urandom_range(99) < pct;
  endfunction

  // request driver and result sink
  always @(negedge clk) begin
    pix_req_t req;
    if (rst_n && (!in_if.valid || in_took)) begin
      if (pixel_fifo.size() != 0 && !idle_now(1'b1)) begin
        req = pixel_fifo.pop_front();
        in_if.cmd <= req.cmd;
        in_if.pixel <= req.pixel;
        in_if.valid <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
    out_if.ready <= rst_n && !idle_now(1'b0);
  end

  int quiet = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
    else quiet++;
    if (quiet >= WD_LIMIT) begin
      $display("sobel_nonmax_suppression: mismatch");
      $finish;
    end
  end

  task automatic settle();
    while (pixel_fifo.size() != 0 || in_if.valid || edge_fifo.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // one frame plus drain; noise flips the cmd, cut truncates the stream
  task automatic push_frame(int unsigned wv, int unsigned hv, int noise, bit binary,
                            int cut, inout int count);
    int unsigned w, h, n;
    pix_req_t req;
    w = clamp_w(wv);
    h = clamp_h(hv);
    n = w * h + 2 * w + 2;
    if (cut > 0 && cut < n) n = cut;
    for (int unsigned t = 0; t < n; t++) begin
      req.cmd = (t >= w * h);
      if ($urandom_range(99) < noise) req.cmd = ~req.cmd;
      req.pixel = binary ? ($urandom_range(1) ? 8'hff : 8'h00) : 8'($urandom_range(255));
      pixel_fifo.push_back(req);
    end
    count += n;
    settle();
  endtask

  initial begin
    int count, w, h;
    count = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (5) @(posedge clk);

    write_reg(CFG_IMAGE_WIDTH, 11'd3);
    write_reg(CFG_IMAGE_HEIGHT, 11'd3);
    push_frame(3, 3, 15, 1'b1, 0, count);
    write_reg(CFG_IMAGE_WIDTH, 11'd0);
    write_reg(CFG_IMAGE_HEIGHT, 11'd1);
    push_frame(0, 1, 0, 1'b0, 0, count);

    write_reg(CFG_IMAGE_WIDTH, 11'd2047);
    write_reg(CFG_IMAGE_HEIGHT, 11'd3);
    push_frame(2047, 3, 2, 1'b0, 40, count);
    write_reg(CFG_IMAGE_WIDTH, 11'd3);
    write_reg(CFG_IMAGE_HEIGHT, 11'd2047);
    push_frame(3, 2047, 2, 1'b1, 200, count);
    write_reg(CFG_IMAGE_WIDTH, 11'd1024);
    write_reg(CFG_IMAGE_HEIGHT, 11'd0);
    push_frame(1024, 0, 0, 1'b0, 40, count);

    w = 3;
    h = 3;
    write_reg(CFG_IMAGE_WIDTH, 11'd3);
    write_reg(CFG_IMAGE_HEIGHT, 11'd3);
    while (count < 2000) begin
      phase = (count < 667) ? 0 : (count < 1334) ? 1 : 2;
      if ($urandom_range(3) != 0) begin
        w = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(3, 12);
        write_reg(CFG_IMAGE_WIDTH, w[CFG_W-1:0]);
      end
      if ($urandom_range(3) != 0) begin
        h = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(3, 10);
        write_reg(CFG_IMAGE_HEIGHT, h[CFG_W-1:0]);
      end
      push_frame(w, h, ($urandom_range(4) == 0) ? 10 : 0, $urandom_range(4) == 0,
                 ($urandom_range(9) == 0) ? $urandom_range(1, 60) : 0, count);
    end

    settle();
    if (errors == 0) begin
      $display("sobel_nonmax_suppression: match");
    end else begin
      $display("sobel_nonmax_suppression: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire
